@@ rtl/vector_min_max_mean_std_defines.svh @@
// Assertion macros shared by the vector statistics block
`ifndef VECTOR_MIN_MAX_MEAN_STD_DEFINES_SVH
`define VECTOR_MIN_MAX_MEAN_STD_DEFINES_SVH

// Antecedent implies consequent in the same cycle
`define VMMS_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Condition never holds
`define VMMS_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("assertion failed");

`endif

@@ rtl/vmms_pkg.sv @@
package vmms_pkg;

  localparam int MaxItems   = 65536;
  localparam int SampleBits = 24;
  localparam int SampleW    = 24;
  localparam int CountW     = 17;
  localparam int SumW       = 40;
  localparam int SqW        = 63;
  localparam int StdW       = 23;
  localparam int QueueDepth = 2;
  localparam int DivSteps   = 64;
  localparam int SqrtSteps  = 32;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      last;
  } in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] smallest;
    logic signed [SampleW-1:0] largest;
    logic signed [SampleW-1:0] average;
    logic [StdW-1:0]           std_dev;
    logic [CountW-1:0]         item_count;
    logic                      overflow;
  } out_t;

  // Totals of one finished vector, handed from front to back
  typedef struct packed {
    logic signed [SampleW-1:0] min_v;
    logic signed [SampleW-1:0] max_v;
    logic signed [SumW-1:0]    sum;
    logic [SqW-1:0]            sumsq;
    logic [CountW-1:0]         count;
    logic                      ovf;
  } record_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV_SUM,
    B_MSQ,
    B_DIV_SQ,
    B_VAR,
    B_SQRT,
    B_OUT
  } back_state_e;

endpackage

@@ rtl/vector_min_max_mean_std.sv @@
// Channel | Signals                       | Direction | Moves per transaction
// in      | in_valid_i in_stall_o in_data_i  | input  | one sample and last flag
// out     | out_valid_o out_stall_i out_data_o | output | statistics of one vector
//
// Samples are taken one per cycle while the result queue (two vectors) has room.
// In the back end each vector result takes two 64-step restoring divisions
// by the count and a 32-step square root.
// Reset (rst_ni low, asynchronous) clears the running totals, queue and output valid flag.
// in_stall_o is high while the queue is full; out_stall_i holds the output register.
`include "vector_min_max_mean_std_defines.svh"

module vector_min_max_mean_std #(
  parameter int MAX_ITEMS   = vmms_pkg::MaxItems,
  parameter int SAMPLE_BITS = vmms_pkg::SampleBits
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  vmms_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output vmms_pkg::out_t out_data_o
);

  logic              accept;
  logic              push, pop, full, avail;
  vmms_pkg::record_t rec_in, rec_out;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !in_stall_o;

  // Front: running totals
  vmms_front #(
    .MAX_ITEMS  (MAX_ITEMS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .data_i  (in_data_i),
    .push_o  (push),
    .rec_o   (rec_in)
  );

  // Queue of finished vectors
  vmms_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rec_i  (rec_in),
    .pop_i  (pop),
    .full_o (full),
    .avail_o(avail),
    .rec_o  (rec_out)
  );

  // Back: divide, square root, output register
  vmms_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .avail_i    (avail),
    .rec_i      (rec_out),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Checks
  `VMMS_ASSERT_NEVER(a_no_push_full, push && full)
  `VMMS_ASSERT_IMPLY(a_count_nonzero, out_valid_o, out_data_o.item_count != '0)
  `VMMS_ASSERT_IMPLY(a_min_le_max, out_valid_o, out_data_o.smallest <= out_data_o.largest)

endmodule

@@ rtl/vmms_front.sv @@
module vmms_front #(
  parameter int MAX_ITEMS   = vmms_pkg::MaxItems,
  parameter int SAMPLE_BITS = vmms_pkg::SampleBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  vmms_pkg::in_t     data_i,
  output logic              push_o,
  output vmms_pkg::record_t rec_o
);

  localparam logic signed [vmms_pkg::SampleW-1:0] TopS =
    vmms_pkg::SampleW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic signed [vmms_pkg::SampleW-1:0] BotS = ~TopS;
  localparam logic [vmms_pkg::CountW-1:0] MaxCnt = vmms_pkg::CountW'(MAX_ITEMS);

  logic signed [vmms_pkg::SampleW-1:0]   min_q, max_q;
  logic signed [vmms_pkg::SumW-1:0]      sum_q;
  logic [vmms_pkg::SqW-1:0]              sq_q;
  logic [vmms_pkg::CountW-1:0]           cnt_q;
  logic                                  ovf_q;
  logic signed [SAMPLE_BITS-1:0]         s_narrow;
  logic signed [vmms_pkg::SampleW-1:0]   s;
  logic signed [2*vmms_pkg::SampleW-1:0] s_sq;
  logic                                  room;
  vmms_pkg::record_t                     upd;

  // Sign-extend the used sample bits, square, and fold into the totals
  always_comb begin
    s_narrow  = data_i.sample[SAMPLE_BITS-1:0];
    s         = vmms_pkg::SampleW'(s_narrow);
    s_sq      = s * s;
    room      = cnt_q < MaxCnt;
    upd.min_v = min_q;
    upd.max_v = max_q;
    upd.sum   = sum_q;
    upd.sumsq = sq_q;
    upd.count = cnt_q;
    upd.ovf   = ovf_q;
    if (room) begin
      if (s < min_q) upd.min_v = s;
      if (s > max_q) upd.max_v = s;
      upd.sum   = sum_q + vmms_pkg::SumW'(s);
      upd.sumsq = sq_q + vmms_pkg::SqW'(unsigned'(s_sq));
      upd.count = cnt_q + 1'b1;
    end else begin
      upd.ovf = 1'b1;
    end
  end

  assign push_o = accept_i && data_i.last;
  assign rec_o  = upd;

  // Totals register; cleared after the last sample of a vector
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= TopS;
      max_q <= BotS;
      sum_q <= '0;
      sq_q  <= '0;
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else if (accept_i) begin
      if (data_i.last) begin
        min_q <= TopS;
        max_q <= BotS;
        sum_q <= '0;
        sq_q  <= '0;
        cnt_q <= '0;
        ovf_q <= 1'b0;
      end else begin
        min_q <= upd.min_v;
        max_q <= upd.max_v;
        sum_q <= upd.sum;
        sq_q  <= upd.sumsq;
        cnt_q <= upd.count;
        ovf_q <= upd.ovf;
      end
    end
  end

endmodule

@@ rtl/vmms_queue.sv @@
module vmms_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  vmms_pkg::record_t rec_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              avail_o,
  output vmms_pkg::record_t rec_o
);

  localparam int PtrW = $clog2(vmms_pkg::QueueDepth);
  localparam int LvlW = $clog2(vmms_pkg::QueueDepth + 1);

  vmms_pkg::record_t mem_q [vmms_pkg::QueueDepth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [LvlW-1:0]   lvl_q;

  assign full_o  = lvl_q == LvlW'(vmms_pkg::QueueDepth);
  assign avail_o = lvl_q != '0;
  assign rec_o   = mem_q[rd_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= rec_i;
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      lvl_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) lvl_q <= lvl_q + 1'b1;
      else if (pop_i && !push_i) lvl_q <= lvl_q - 1'b1;
    end
  end

endmodule

@@ rtl/vmms_back.sv @@
module vmms_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              avail_i,
  input  vmms_pkg::record_t rec_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output vmms_pkg::out_t    out_data_o
);

  localparam logic [63:0] SqrtTop = 64'd1 << 62;
  localparam logic [63:0] StdMax  = 64'((1 << vmms_pkg::StdW) - 1);

  vmms_pkg::back_state_e state_q, state_d;
  vmms_pkg::record_t     rec_q;
  logic [63:0]           dvd_q, dvd_d;
  logic [15:0]           rem_q;
  logic [16:0]           rem_d, r;
  logic                  ge;
  logic [5:0]            cnt_q, cnt_d;
  logic signed [vmms_pkg::SampleW-1:0]   mean_q, mean_d;
  logic [2*vmms_pkg::SampleW-1:0]        msq_q, msq_d;
  logic [63:0]           avg_q, avg_d;
  logic [63:0]           v_q, v_d, root_q, root_d, bit_q, bit_d, t;
  logic                  load_rec;
  logic                  out_load;
  logic                  out_valid_q;
  vmms_pkg::out_t        out_q, out_d;
  logic [63:0]           q_signed;

  // One restoring division step and one square root step
  always_comb begin
    r     = {rem_q, dvd_q[63]};
    ge    = r >= rec_q.count;
    rem_d = ge ? r - rec_q.count : r;
    t     = root_q + bit_q;
  end

  assign q_signed = rec_q.sum[vmms_pkg::SumW-1] ? -{dvd_q[62:0], ge} : {dvd_q[62:0], ge};

  // Sequencer: next state and datapath loads
  always_comb begin
    state_d  = state_q;
    dvd_d    = dvd_q;
    cnt_d    = cnt_q;
    mean_d   = mean_q;
    msq_d    = msq_q;
    avg_d    = avg_q;
    v_d      = v_q;
    root_d   = root_q;
    bit_d    = bit_q;
    load_rec = 1'b0;
    out_load = 1'b0;
    out_d    = out_q;
    pop_o    = 1'b0;
    case (state_q)
      vmms_pkg::B_IDLE: begin
        if (avail_i) begin
          pop_o    = 1'b1;
          load_rec = 1'b1;
          state_d  = vmms_pkg::B_DIV_SUM;
        end
      end
      vmms_pkg::B_DIV_SUM: begin
        dvd_d = {dvd_q[62:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 6'(vmms_pkg::DivSteps - 1)) begin
          mean_d  = (rec_q.count == '0) ? '0 : vmms_pkg::SampleW'(q_signed);
          state_d = vmms_pkg::B_MSQ;
        end
      end
      vmms_pkg::B_MSQ: begin
        msq_d   = unsigned'((2*vmms_pkg::SampleW)'(mean_q) *
                            (2*vmms_pkg::SampleW)'(mean_q));
        dvd_d   = 64'(rec_q.sumsq);
        cnt_d   = '0;
        state_d = vmms_pkg::B_DIV_SQ;
      end
      vmms_pkg::B_DIV_SQ: begin
        dvd_d = {dvd_q[62:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 6'(vmms_pkg::DivSteps - 1)) begin
          avg_d   = (rec_q.count == '0) ? '0 : {dvd_q[62:0], ge};
          state_d = vmms_pkg::B_VAR;
        end
      end
      vmms_pkg::B_VAR: begin
        v_d     = (avg_q > 64'(msq_q)) ? avg_q - 64'(msq_q) : '0;
        root_d  = '0;
        bit_d   = SqrtTop;
        cnt_d   = '0;
        state_d = vmms_pkg::B_SQRT;
      end
      vmms_pkg::B_SQRT: begin
        if (v_q >= t) begin
          v_d    = v_q - t;
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 6'(vmms_pkg::SqrtSteps - 1)) state_d = vmms_pkg::B_OUT;
      end
      vmms_pkg::B_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load         = 1'b1;
          out_d.smallest   = rec_q.min_v;
          out_d.largest    = rec_q.max_v;
          out_d.average    = mean_q;
          out_d.std_dev    = (root_q > StdMax) ? vmms_pkg::StdW'(StdMax)
                                               : root_q[vmms_pkg::StdW-1:0];
          out_d.item_count = rec_q.count;
          out_d.overflow   = rec_q.ovf;
          state_d          = vmms_pkg::B_IDLE;
        end
      end
      default: state_d = vmms_pkg::B_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vmms_pkg::B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (load_rec) begin
      rec_q <= rec_i;
      dvd_q <= 64'(unsigned'(rec_i.sum[vmms_pkg::SumW-1] ? -rec_i.sum : rec_i.sum));
      rem_q <= '0;
      cnt_q <= '0;
    end else begin
      dvd_q <= dvd_d;
      cnt_q <= cnt_d;
      if (state_q == vmms_pkg::B_DIV_SUM || state_q == vmms_pkg::B_DIV_SQ)
        rem_q <= rem_d[15:0];
      else
        rem_q <= '0;
    end
    mean_q <= mean_d;
    msq_q  <= msq_d;
    avg_q  <= avg_d;
    v_q    <= v_d;
    root_q <= root_d;
    bit_q  <= bit_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
